@@ rtl/core/cdms_pkg.sv @@
// Package: shared types and constants of the millisecond countdown clock.
`default_nettype none

package cdms_pkg;

  localparam int TOTAL_W = 27;
  localparam int DELTA_W = 16;
  localparam int FIELD_W = 16;
  localparam int HOURS_W = 5;
  localparam int MINUTES_W = 6;
  localparam int SECONDS_W = 6;
  localparam int MILLIS_W = 10;

  localparam int CDMS_QUEUE_DEPTH = 4;

  localparam logic [TOTAL_W-1:0] RESET_MS = TOTAL_W'(180000);
  localparam logic [TOTAL_W-1:0] DAY_MS = TOTAL_W'(86400000);
  localparam logic [TOTAL_W-1:0] HOUR_MS = TOTAL_W'(3600000);
  localparam logic [TOTAL_W-1:0] MIN_MS = TOTAL_W'(60000);
  localparam logic [TOTAL_W-1:0] SEC_MS = TOTAL_W'(1000);

  localparam logic signed [FIELD_W-1:0] HOURS_MAX = 16'sd23;
  localparam logic signed [FIELD_W-1:0] MINSEC_MAX = 16'sd59;
  localparam logic signed [FIELD_W-1:0] MILLIS_MAX = 16'sd999;

  // Exact reciprocal division: q = (x * RECIP) >> SHIFT
  localparam int SEC_RECIP_W = 28;
  localparam int SEC_SHIFT = 37;
  localparam int SEC_PROD_W = TOTAL_W + SEC_RECIP_W;
  localparam int SEC_Q_W = SEC_PROD_W - SEC_SHIFT;
  localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = SEC_RECIP_W'(137438954);

  localparam int MIN_RECIP_W = 19;
  localparam int MIN_SHIFT = 24;
  localparam int MIN_PROD_W = SEC_Q_W + MIN_RECIP_W;
  localparam int MIN_Q_W = MIN_PROD_W - MIN_SHIFT;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = MIN_RECIP_W'(279621);

  localparam int HOUR_RECIP_W = 14;
  localparam int HOUR_SHIFT = 19;
  localparam int HOUR_PROD_W = MIN_Q_W + HOUR_RECIP_W;
  localparam int HOUR_Q_W = HOUR_PROD_W - HOUR_SHIFT;
  localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP = HOUR_RECIP_W'(8739);

  localparam logic [MINUTES_W-1:0] SIXTY = MINUTES_W'(60);

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_SET  = 1'b1
  } cdms_func_t;

  typedef struct packed {
    cdms_func_t          func;
    logic [TOTAL_W-1:0]  value;
  } cdms_op_t;

endpackage

`default_nettype wire

@@ rtl/core/cdms_if.sv @@
// Interfaces: item, result and configuration channels.
`default_nettype none

interface cdms_item_if;
  import cdms_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [DELTA_W-1:0]         delta_ms;
  logic signed [FIELD_W-1:0]  set_hours;
  logic signed [FIELD_W-1:0]  set_minutes;
  logic signed [FIELD_W-1:0]  set_seconds;
  logic signed [FIELD_W-1:0]  set_millis;

  modport source (output valid, func, delta_ms, set_hours, set_minutes, set_seconds,
                  set_millis, input ready);
  modport sink (input valid, func, delta_ms, set_hours, set_minutes, set_seconds,
                set_millis, output ready);
endinterface

interface cdms_result_if;
  import cdms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [HOURS_W-1:0]    hours;
  logic [MINUTES_W-1:0]  minutes;
  logic [SECONDS_W-1:0]  seconds;
  logic [MILLIS_W-1:0]   millis;

  modport source (output valid, hours, minutes, seconds, millis, input ready);
  modport sink (input valid, hours, minutes, seconds, millis, output ready);
endinterface

interface cdms_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cdms_front.sv @@
// Front end: accept items, clamp set fields and build the loaded total.
`default_nettype none

module cdms_front (
  input  logic              clk,
  input  logic              rst,
  cdms_item_if.sink         item,
  output logic              push_valid,
  input  logic              push_ready,
  output cdms_pkg::cdms_op_t push_op
);
  import cdms_pkg::*;

  function automatic logic [MILLIS_W-1:0] clamp_sat(
    input logic signed [FIELD_W-1:0] v,
    input logic signed [FIELD_W-1:0] hi
  );
    logic [MILLIS_W-1:0] r;
    if (v < 16'sd0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi[MILLIS_W-1:0];
    end else begin
      r = v[MILLIS_W-1:0];
    end
    return r;
  endfunction

  logic                  adv;
  logic                  f1_valid;
  cdms_func_t            f1_func;
  logic [DELTA_W-1:0]    f1_delta;
  logic [HOURS_W-1:0]    f1_hours;
  logic [MINUTES_W-1:0]  f1_minutes;
  logic [SECONDS_W-1:0]  f1_seconds;
  logic [MILLIS_W-1:0]   f1_millis;
  logic [HOURS_W-1:0]    hours_clamped;

  logic                  f2_valid;
  cdms_func_t            f2_func;
  logic [DELTA_W-1:0]    f2_delta;
  logic [TOTAL_W-1:0]    f2_hm;
  logic [TOTAL_W-1:0]    f2_sl;

  assign adv = !f2_valid || push_ready;
  assign item.ready = adv && !rst;

  // hours outside 0..23 load as zero
  assign hours_clamped = (item.set_hours < 16'sd0 || item.set_hours > HOURS_MAX) ?
                         '0 : item.set_hours[HOURS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= item.valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_func    <= cdms_func_t'(item.func);
      f1_delta   <= item.delta_ms;
      f1_hours   <= hours_clamped;
      f1_minutes <= MINUTES_W'(clamp_sat(item.set_minutes, MINSEC_MAX));
      f1_seconds <= SECONDS_W'(clamp_sat(item.set_seconds, MINSEC_MAX));
      f1_millis  <= clamp_sat(item.set_millis, MILLIS_MAX);
      f2_func    <= f1_func;
      f2_delta   <= f1_delta;
      f2_hm      <= TOTAL_W'(f1_hours) * HOUR_MS + TOTAL_W'(f1_minutes) * MIN_MS;
      f2_sl      <= TOTAL_W'(f1_seconds) * SEC_MS + TOTAL_W'(f1_millis);
    end
  end

  assign push_valid    = f2_valid;
  assign push_op.func  = f2_func;
  assign push_op.value = (f2_func == FUNC_SET) ? f2_hm + f2_sl : TOTAL_W'(f2_delta);

endmodule

`default_nettype wire

@@ rtl/core/cdms_queue.sv @@
// Queue: short FIFO between the front and back ends.
`default_nettype none

module cdms_queue #(
  parameter int unsigned DEPTH = cdms_pkg::CDMS_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  cdms_pkg::cdms_op_t push_op,
  output logic               pop_valid,
  input  logic               pop_ready,
  output cdms_pkg::cdms_op_t pop_op
);
  import cdms_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cdms_op_t           entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cdms_back.sv @@
// Back end: update the total, then split it into h, m, s, ms over four stages.
`default_nettype none

module cdms_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  cdms_pkg::cdms_op_t pop_op,
  cdms_cfg_if.sink           cfg,
  cdms_result_if.source      result
);
  import cdms_pkg::*;

  logic                    adv;
  logic                    pop;
  logic                    count_up;
  logic [TOTAL_W-1:0]      total;
  logic [TOTAL_W-1:0]      total_next;
  logic [TOTAL_W:0]        tick_sum;
  logic [TOTAL_W:0]        tick_val;
  logic [TOTAL_W:0]        tick_wrap;

  logic                    v1;
  logic                    v2;
  logic                    v3;
  logic                    v4;
  logic                    v5;
  logic [TOTAL_W-1:0]      t2;
  logic [SEC_PROD_W-1:0]   p2;
  logic [SEC_Q_W-1:0]      q1;
  logic [TOTAL_W-1:0]      ms_rem;
  logic [MILLIS_W-1:0]     ms3;
  logic [SEC_Q_W-1:0]      q1_3;
  logic [MIN_PROD_W-1:0]   p3;
  logic [MIN_Q_W-1:0]      q2;
  logic [SEC_Q_W-1:0]      sec_rem;
  logic [MILLIS_W-1:0]     ms4;
  logic [SECONDS_W-1:0]    sec4;
  logic [MIN_Q_W-1:0]      q2_4;
  logic [HOUR_PROD_W-1:0]  p4;
  logic [HOUR_Q_W-1:0]     hrs;
  logic [MIN_Q_W-1:0]      min_rem;

  assign adv = !v5 || result.ready;
  assign pop_ready = adv;
  assign pop = pop_valid && adv;
  assign cfg.ready = !rst;

  always_comb begin
    tick_sum = {1'b0, total} + {1'b0, pop_op.value};
    priority if (count_up) begin
      tick_val = tick_sum;
    end else if (pop_op.value > total) begin
      tick_val = '0;
    end else begin
      tick_val = {1'b0, total - pop_op.value};
    end
    tick_wrap = (tick_val >= {1'b0, DAY_MS}) ? tick_val - {1'b0, DAY_MS} : tick_val;
    unique case (pop_op.func)
      FUNC_SET:  total_next = pop_op.value;
      FUNC_TICK: total_next = tick_wrap[TOTAL_W-1:0];
      default:   total_next = total;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_up <= 1'b0;
      total    <= RESET_MS;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (cfg.valid) begin
        count_up <= cfg.data;
      end
      if (pop) begin
        total <= total_next;
      end
      if (adv) begin
        v1 <= pop;
        v2 <= v1;
        v3 <= v2;
        v4 <= v3;
        v5 <= v4;
      end
    end
  end

  assign q1      = p2[SEC_SHIFT +: SEC_Q_W];
  assign ms_rem  = t2 - TOTAL_W'(q1) * SEC_MS;
  assign q2      = p3[MIN_SHIFT +: MIN_Q_W];
  assign sec_rem = q1_3 - SEC_Q_W'(q2) * SEC_Q_W'(SIXTY);
  assign hrs     = p4[HOUR_SHIFT +: HOUR_Q_W];
  assign min_rem = q2_4 - MIN_Q_W'(hrs) * MIN_Q_W'(SIXTY);

  always_ff @(posedge clk) begin
    if (adv) begin
      t2   <= total;
      p2   <= SEC_PROD_W'(total) * SEC_PROD_W'(SEC_RECIP);
      ms3  <= ms_rem[MILLIS_W-1:0];
      q1_3 <= q1;
      p3   <= MIN_PROD_W'(q1) * MIN_PROD_W'(MIN_RECIP);
      ms4  <= ms3;
      sec4 <= sec_rem[SECONDS_W-1:0];
      q2_4 <= q2;
      p4   <= HOUR_PROD_W'(q2) * HOUR_PROD_W'(HOUR_RECIP);
      result.millis  <= ms4;
      result.seconds <= sec4;
      result.minutes <= min_rem[MINUTES_W-1:0];
      result.hours   <= hrs[HOURS_W-1:0];
    end
  end

  assign result.valid = v5;

endmodule

`default_nettype wire

@@ rtl/core/countdown_ms_clock_split.sv @@
// Top level: millisecond countdown clock with a split h/m/s/ms result.
// Path: f1, f2, queue, total register (one add and compare step), split stages.
// Throughput: one item per cycle while result.ready does not stall the back end.
// The split runs as three reciprocal-multiply divider stages plus an output register.
// Reset: total is 180000 ms (three minutes), count direction is down, queue empty.
`default_nettype none

module countdown_ms_clock_split #(
  parameter int unsigned QUEUE_DEPTH = cdms_pkg::CDMS_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  cdms_item_if.sink     item,
  cdms_result_if.source result,
  cdms_cfg_if.sink      cfg
);
  import cdms_pkg::*;

  logic      push_valid;
  logic      push_ready;
  cdms_op_t  push_op;
  logic      pop_valid;
  logic      pop_ready;
  cdms_op_t  pop_op;

  cdms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  cdms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  cdms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .cfg       (cfg),
    .result    (result)
  );

endmodule

`default_nettype wire

@@ dv/countdown_ms_clock_split_tb.sv @@
// Testbench: checks the millisecond clock split against a cycle-free model and directed rows.
`default_nettype none

module countdown_ms_clock_split_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cdms_pkg::*;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    cdms_func_t                func;
    logic [DELTA_W-1:0]        delta_ms;
    logic signed [FIELD_W-1:0] set_hours;
    logic signed [FIELD_W-1:0] set_minutes;
    logic signed [FIELD_W-1:0] set_seconds;
    logic signed [FIELD_W-1:0] set_millis;
  } clock_item_t;

  typedef struct packed {
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECONDS_W-1:0] seconds;
    logic [MILLIS_W-1:0]  millis;
  } clock_split_t;

  typedef struct packed {
    row_kind_t    kind;
    logic         cfg_val;
    clock_item_t  item;
    logic         typed;
    clock_split_t split;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_ITEM, 1'b0, '{FUNC_TICK, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      1'b1, '{5'd0, 6'd3, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_TICK, 16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      1'b0, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_SET, 16'h0000, 16'sd23, 16'sd59, 16'sd59, 16'sd999},
      1'b1, '{5'd23, 6'd59, 6'd59, 10'd999}},
    '{ROW_ITEM, 1'b0, '{FUNC_SET, 16'h0000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
      1'b1, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_SET, 16'h0000, 16'sd24, 16'sd0, 16'sd0, 16'sd0},
      1'b1, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_SET, 16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
      1'b1, '{5'd0, 6'd59, 6'd59, 10'd999}},
    '{ROW_ITEM, 1'b0, '{FUNC_SET, 16'h0000, 16'sd0, 16'sd60, 16'sd60, 16'sd1000},
      1'b1, '{5'd0, 6'd59, 6'd59, 10'd999}},
    '{ROW_ITEM, 1'b0, '{FUNC_SET, 16'hFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF},
      1'b1, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_SET, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd5},
      1'b1, '{5'd0, 6'd0, 6'd0, 10'd5}},
    '{ROW_ITEM, 1'b0, '{FUNC_TICK, 16'h0006, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
      1'b1, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_TICK, 16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      1'b1, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_SET, 16'h5A5A, 16'sd12, 16'sd34, 16'sd56, 16'sd789},
      1'b1, '{5'd12, 6'd34, 6'd56, 10'd789}},
    '{ROW_ITEM, 1'b0, '{FUNC_TICK, 16'h0001, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      1'b0, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_TICK, 16'h8000, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF},
      1'b0, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_CFG, 1'b1, '{FUNC_TICK, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      1'b0, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_SET, 16'h0000, 16'sd23, 16'sd59, 16'sd59, 16'sd999},
      1'b1, '{5'd23, 6'd59, 6'd59, 10'd999}},
    '{ROW_ITEM, 1'b0, '{FUNC_TICK, 16'h0001, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      1'b1, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_SET, 16'h0000, 16'sd23, 16'sd59, 16'sd59, 16'sd0},
      1'b1, '{5'd23, 6'd59, 6'd59, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_TICK, 16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      1'b0, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_TICK, 16'h0000, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555},
      1'b0, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_SET, 16'hAAAA, 16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555},
      1'b1, '{5'd0, 6'd59, 6'd59, 10'd999}},
    '{ROW_ITEM, 1'b0, '{FUNC_TICK, 16'h5555, 16'shAAAA, 16'shAAAA, 16'shAAAA, 16'shAAAA},
      1'b0, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_CFG, 1'b0, '{FUNC_TICK, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      1'b0, '{5'd0, 6'd0, 6'd0, 10'd0}},
    '{ROW_ITEM, 1'b0, '{FUNC_TICK, 16'hAAAA, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      1'b0, '{5'd0, 6'd0, 6'd0, 10'd0}}
  };

  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 140;

  logic clk = 1'b0;
  logic rst;

  cdms_item_if   item_ch ();
  cdms_result_if res_ch ();
  cdms_cfg_if    cfg_ch ();

  countdown_ms_clock_split i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [31:0]  model_total = 32'(RESET_MS);
  logic         model_count_up = 1'b0;
  clock_split_t expected_splits [$];
  int           mismatch_count = 0;
  idle_mode_t   idle_mode = IDLE_NONE;
  bit           drain_enable = 1'b0;

  function automatic int unsigned clamp_set(logic signed [FIELD_W-1:0] v, int hi,
                                            bit zero_over);
    if (v < 0) return 0;
    if (int'(v) > hi) return zero_over ? 0 : hi;
    return int'(v);
  endfunction

  // Update the model total with one item and return its split.
  function automatic clock_split_t advance_clock(clock_item_t it);
    int unsigned  h, m, s, ms;
    logic [31:0]  t;
    clock_split_t r;
    if (it.func == FUNC_SET) begin
      h  = clamp_set(it.set_hours, 23, 1'b1);
      m  = clamp_set(it.set_minutes, 59, 1'b0);
      s  = clamp_set(it.set_seconds, 59, 1'b0);
      ms = clamp_set(it.set_millis, 999, 1'b0);
      model_total = h * 32'(HOUR_MS) + m * 32'(MIN_MS) + s * 32'(SEC_MS) + ms;
    end else begin
      if (model_count_up) model_total = model_total + 32'(it.delta_ms);
      else if (32'(it.delta_ms) > model_total) model_total = 32'd0;
      else model_total = model_total - 32'(it.delta_ms);
      if (model_total >= 32'(DAY_MS)) model_total = model_total % 32'(DAY_MS);
    end
    model_total = model_total & 32'h07FF_FFFF;
    t = model_total;
    r.millis  = MILLIS_W'(t % 1000);
    t = t / 1000;
    r.seconds = SECONDS_W'(t % 60);
    t = t / 60;
    r.minutes = MINUTES_W'(t % 60);
    t = t / 60;
    r.hours   = HOURS_W'(t);
    return r;
  endfunction

  function automatic logic signed [FIELD_W-1:0] noisy_field(int hi);
    case ($urandom_range(5))
      0: return 16'shFFFF;
      1: return FIELD_W'(hi + 1);
      2: return FIELD_W'(hi);
      3: return 16'sh0000;
      4: return 16'sh8000;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  function automatic clock_item_t rand_item();
    clock_item_t it;
    int          r;
    it.delta_ms    = DELTA_W'($urandom);
    it.set_hours   = FIELD_W'($urandom);
    it.set_minutes = FIELD_W'($urandom);
    it.set_seconds = FIELD_W'($urandom);
    it.set_millis  = FIELD_W'($urandom);
    r = $urandom_range(99);
    if (r < 45) begin
      it.func = FUNC_TICK;
      case ($urandom_range(3))
        0, 1: it.delta_ms = DELTA_W'($urandom_range(1500));
        2: ;
        default: begin
          case ($urandom_range(3))
            0: it.delta_ms = 16'h0000;
            1: it.delta_ms = 16'h0001;
            2: it.delta_ms = 16'hFFFE;
            default: it.delta_ms = 16'hFFFF;
          endcase
        end
      endcase
    end else if (r < 85) begin
      it.func = FUNC_SET;
      case ($urandom_range(3))
        0: begin
          it.set_hours   = 16'sd0;
          it.set_minutes = FIELD_W'($urandom_range(1));
        end
        1: begin
          it.set_hours   = 16'sd23;
          it.set_minutes = 16'sd59;
        end
        default: begin
          it.set_hours   = FIELD_W'($urandom_range(23));
          it.set_minutes = FIELD_W'($urandom_range(59));
        end
      endcase
      it.set_seconds = FIELD_W'($urandom_range(59));
      it.set_millis  = FIELD_W'($urandom_range(999));
    end else begin
      it.func        = FUNC_SET;
      it.set_hours   = noisy_field(23);
      it.set_minutes = noisy_field(59);
      it.set_seconds = noisy_field(59);
      it.set_millis  = noisy_field(999);
    end
    return it;
  endfunction

  task automatic send_item(clock_item_t it, bit typed, clock_split_t typed_split);
    clock_split_t predicted;
    if (drain_enable && $urandom_range(49) == 0) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
      while (expected_splits.size() != 0) @(posedge clk);
    end
    while ((idle_mode == IDLE_SEND && $urandom_range(99) < 75) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 18)) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.func        <= it.func;
    item_ch.delta_ms    <= it.delta_ms;
    item_ch.set_hours   <= it.set_hours;
    item_ch.set_minutes <= it.set_minutes;
    item_ch.set_seconds <= it.set_seconds;
    item_ch.set_millis  <= it.set_millis;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predicted = advance_clock(it);
    expected_splits.insert(expected_splits.size(), typed ? typed_split : predicted);
  endtask

  task automatic write_count_up(logic v);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_splits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    model_count_up = v;
  endtask

  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECV: res_ch.ready <= ($urandom_range(99) >= 75);
      IDLE_BOTH: res_ch.ready <= ($urandom_range(99) >= 18);
      default:   res_ch.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin : check_results
    clock_split_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.hours, res_ch.minutes, res_ch.seconds, res_ch.millis};
      if (expected_splits.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result %0d:%0d:%0d.%0d", got.hours, got.minutes,
                   got.seconds, got.millis);
        mismatch_count++;
      end else begin
        want = expected_splits.pop_front();
        if (got.hours != want.hours || got.minutes != want.minutes ||
            got.seconds != want.seconds || got.millis != want.millis) begin
          if (mismatch_count < 10)
            $display("mismatch: expected %0d:%0d:%0d.%0d, got %0d:%0d:%0d.%0d",
                     want.hours, want.minutes, want.seconds, want.millis,
                     got.hours, got.minutes, got.seconds, got.millis);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("countdown_ms_clock_split_tb failed");
    $finish;
  end

  initial begin
    idle_mode_t mode;
    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.func        <= FUNC_TICK;
    item_ch.delta_ms    <= '0;
    item_ch.set_hours   <= '0;
    item_ch.set_minutes <= '0;
    item_ch.set_seconds <= '0;
    item_ch.set_millis  <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        write_count_up(DIR_TABLE[i].cfg_val);
      end else begin
        send_item(DIR_TABLE[i].item, DIR_TABLE[i].typed, DIR_TABLE[i].split);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      mode = idle_mode_t'(p % 4);
      write_count_up(logic'(((p >> 2) ^ p) & 1));
      idle_mode    = mode;
      drain_enable = (mode != IDLE_NONE);
      repeat (PHASE_ITEMS) send_item(rand_item(), 1'b0, '0);
    end

    item_ch.valid <= 1'b0;
    while (expected_splits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_splits.size() == 0) begin
      $display("countdown_ms_clock_split_tb passed");
    end else begin
      $display("countdown_ms_clock_split_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
